// ===== hdl/mime_content_type_parser_defines.svh =====
// assertion macros for the content-type parser
`ifndef MIME_CONTENT_TYPE_PARSER_DEFINES_SVH
`define MIME_CONTENT_TYPE_PARSER_DEFINES_SVH

// checked on every rising edge outside reset
`define MCTP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be true outside reset
`define MCTP_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/mctp_pkg.sv =====
// types, codes and byte classification for the content-type parser
`default_nettype none
package mctp_pkg;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       final_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [2:0] byte_role;
		logic       field_start;
		logic       failed;
		logic       accepted;
		logic       end_of_header;
	} out_word_t;

	typedef struct packed {
		logic tok;
		logic ws;
		logic slash;
		logic semi;
		logic eq;
		logic quote;
		logic bslash;
	} class_t;

	typedef struct packed {
		in_word_t word;
		class_t   cls;
	} cls_word_t;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	localparam logic [3:0] PH_MEDIA_FIRST = 4'd0;
	localparam logic [3:0] PH_MEDIA       = 4'd1;
	localparam logic [3:0] PH_SUB_FIRST   = 4'd2;
	localparam logic [3:0] PH_SUB         = 4'd3;
	localparam logic [3:0] PH_AFTER_VAL   = 4'd4;
	localparam logic [3:0] PH_AFTER_SEMI  = 4'd5;
	localparam logic [3:0] PH_NAME        = 4'd6;
	localparam logic [3:0] PH_AFTER_EQ    = 4'd7;
	localparam logic [3:0] PH_VAL_TOK     = 4'd8;
	localparam logic [3:0] PH_QUOTE_FIRST = 4'd9;
	localparam logic [3:0] PH_QUOTE       = 4'd10;
	localparam logic [3:0] PH_QESC_FIRST  = 4'd11;
	localparam logic [3:0] PH_QESC        = 4'd12;
	localparam logic [3:0] PH_ERROR       = 4'd13;

	localparam logic [2:0] ROLE_MEDIA  = 3'd0;
	localparam logic [2:0] ROLE_SUB    = 3'd1;
	localparam logic [2:0] ROLE_NAME   = 3'd2;
	localparam logic [2:0] ROLE_VALUE  = 3'd3;
	localparam logic [2:0] ROLE_SYNTAX = 3'd4;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_DEL    = 8'h7f;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;

	function automatic class_t classify(input logic [7:0] c);
		class_t r;
		r.tok    = (c > CH_SPACE) && (c < CH_DEL) &&
			!(c inside {8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, CH_SEMI, 8'h3a,
				CH_BSLASH, CH_QUOTE, CH_SLASH, 8'h5b, 8'h5d, 8'h3f, CH_EQ});
		r.ws     = (c == CH_SPACE) || (c == CH_TAB);
		r.slash  = (c == CH_SLASH);
		r.semi   = (c == CH_SEMI);
		r.eq     = (c == CH_EQ);
		r.quote  = (c == CH_QUOTE);
		r.bslash = (c == CH_BSLASH);
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/mctp_front.sv =====
// front end: byte classification and the word queue towards the parser
`default_nettype none
module mctp_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  mctp_pkg::in_word_t  item,
	output logic                q_valid,
	input  wire                 q_take,
	output mctp_pkg::cls_word_t q_word
);
	import mctp_pkg::*;

	cls_word_t        mem_q [QDEPTH];
	logic [QAW-1:0]   wr_q;
	logic [QAW-1:0]   rd_q;
	logic [QAW:0]     cnt_q;
	logic             wr_en;
	logic             rd_en;

	assign full    = (cnt_q == (QAW+1)'(QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign wr_en   = push && !full;
	assign rd_en   = q_take && q_valid;
	assign q_word  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en)
				wr_q <= wr_q + 1'b1;
			if (rd_en)
				rd_q <= rd_q + 1'b1;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 1'b1;
			else if (!wr_en && rd_en)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q].word <= item;
			mem_q[wr_q].cls  <= classify(item.char_byte);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mctp_back.sv =====
// back end: parse state machine and result register
`default_nettype none
`include "mime_content_type_parser_defines.svh"
module mctp_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_valid,
	output logic                q_take,
	input  mctp_pkg::cls_word_t q_word,
	output logic                empty,
	input  wire                 pop,
	output mctp_pkg::out_word_t result
);
	import mctp_pkg::*;

	logic [3:0] phase_q;
	logic       out_v_q;
	out_word_t  out_q;
	logic [3:0] nx;
	logic [3:0] nx_fin;
	logic [2:0] role;
	logic       start;
	logic       failed;
	logic       complete;
	logic       load;
	class_t     c;

	assign c      = q_word.cls;
	assign load   = q_valid && (!out_v_q || pop);
	assign q_take = load;
	assign empty  = !out_v_q;
	assign result = out_q;

	always_comb begin
		nx    = PH_ERROR;
		role  = ROLE_SYNTAX;
		start = 1'b0;
		case (phase_q)
			PH_MEDIA_FIRST: begin
				if (c.tok) begin
					nx = PH_MEDIA; role = ROLE_MEDIA; start = 1'b1;
				end
			end
			PH_MEDIA: begin
				if (c.tok) begin
					nx = PH_MEDIA; role = ROLE_MEDIA;
				end else if (c.slash)
					nx = PH_SUB_FIRST;
			end
			PH_SUB_FIRST: begin
				if (c.tok) begin
					nx = PH_SUB; role = ROLE_SUB; start = 1'b1;
				end
			end
			PH_SUB, PH_VAL_TOK: begin
				if (c.tok) begin
					nx   = phase_q;
					role = (phase_q == PH_SUB) ? ROLE_SUB : ROLE_VALUE;
				end else if (c.ws)
					nx = PH_AFTER_VAL;
				else if (c.semi)
					nx = PH_AFTER_SEMI;
			end
			PH_AFTER_VAL: begin
				if (c.ws)
					nx = PH_AFTER_VAL;
				else if (c.semi)
					nx = PH_AFTER_SEMI;
			end
			PH_AFTER_SEMI: begin
				if (c.ws)
					nx = PH_AFTER_SEMI;
				else if (c.tok) begin
					nx = PH_NAME; role = ROLE_NAME; start = 1'b1;
				end
			end
			PH_NAME: begin
				if (c.tok) begin
					nx = PH_NAME; role = ROLE_NAME;
				end else if (c.eq)
					nx = PH_AFTER_EQ;
			end
			PH_AFTER_EQ: begin
				if (c.ws)
					nx = PH_AFTER_EQ;
				else if (c.quote)
					nx = PH_QUOTE_FIRST;
				else if (c.tok) begin
					nx = PH_VAL_TOK; role = ROLE_VALUE; start = 1'b1;
				end
			end
			PH_QUOTE_FIRST, PH_QUOTE: begin
				if (c.quote)
					nx = PH_AFTER_VAL;
				else if (c.bslash)
					nx = (phase_q == PH_QUOTE_FIRST) ? PH_QESC_FIRST : PH_QESC;
				else begin
					nx    = PH_QUOTE;
					role  = ROLE_VALUE;
					start = (phase_q == PH_QUOTE_FIRST);
				end
			end
			PH_QESC_FIRST, PH_QESC: begin
				nx    = PH_QUOTE;
				role  = ROLE_VALUE;
				start = (phase_q == PH_QESC_FIRST);
			end
			default: begin
				nx = PH_ERROR;
			end
		endcase
	end

	assign complete = nx inside {PH_SUB, PH_AFTER_VAL, PH_AFTER_SEMI, PH_VAL_TOK};
	assign failed   = (nx == PH_ERROR) || (q_word.word.final_byte && !complete);
	assign nx_fin   = q_word.word.final_byte ? PH_MEDIA_FIRST : nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MEDIA_FIRST;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q <= nx_fin;
				out_v_q <= 1'b1;
			end else if (pop)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.data_byte     <= q_word.word.char_byte;
			out_q.byte_role     <= role;
			out_q.field_start   <= start;
			out_q.failed        <= failed;
			out_q.accepted      <= q_word.word.final_byte && !failed;
			out_q.end_of_header <= q_word.word.final_byte;
		end
	end

	`MCTP_ASSERT(a_restart, (load && q_word.word.final_byte) |=> (phase_q == PH_MEDIA_FIRST), "parse did not restart after last word")
	`MCTP_NEVER(a_acc_ok, out_v_q && out_q.accepted && (out_q.failed || !out_q.end_of_header), "accepted without a clean last word")
	`MCTP_NEVER(a_start_role, out_v_q && out_q.field_start && (out_q.byte_role == ROLE_SYNTAX), "field start on a syntax word")
	`MCTP_ASSERT(a_hold, (out_v_q && !pop) |=> (out_v_q && $stable(out_q)), "waiting result changed")

endmodule
`default_nettype wire

// ===== hdl/mime_content_type_parser.sv =====
// top level of the content-type header parser
// Takes one header byte per push with a last-byte mark and returns one tagged result word per
// byte, in order. Sustained rate is one byte per clock while results are popped at once: the
// front end classifies each byte and parks it in a four-word queue, the back end advances the
// parse state machine once per byte and holds the result in an output register that refills in
// the same cycle it is popped if a word is queued. Bytes pass the queue, then the output register.
// Errors stay set until the last byte, after which the parse starts again from the media type.
`default_nettype none
module mime_content_type_parser (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  mctp_pkg::in_word_t  item,
	output logic                empty,
	input  wire                 pop,
	output mctp_pkg::out_word_t result
);
	import mctp_pkg::*;

	logic      q_valid;
	logic      q_take;
	cls_word_t q_word;

	mctp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.q_valid (q_valid),
		.q_take  (q_take),
		.q_word  (q_word)
	);

	mctp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_take  (q_take),
		.q_word  (q_word),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
`default_nettype wire
